// ===== hw/rtl/socm_pkg.sv =====
// Shared types, codes and constants of the strip occupancy and coincidence monitor.
package socm_pkg;

  // Geometry of the detector.
  localparam int unsigned N_STATIONS   = 3;
  localparam int unsigned N_MOD_MAX    = 4;
  localparam int unsigned N_OCC_HIST   = 16;

  // Field widths fixed by the interface.
  localparam int unsigned STRIP_W      = 10;
  localparam int unsigned HIST_W       = 4;
  localparam int unsigned AMP_BIN_W    = 8;
  localparam int unsigned RESULT_W     = 32;

  // |amplitude| / 10 as a multiplication by a reciprocal; exact for all 17-bit magnitudes
  // up to 81919, which covers 0 to 32768.
  localparam int unsigned MAG_W        = 17;
  localparam int unsigned RECIP_W      = 16;
  localparam int unsigned PROD_W       = MAG_W + RECIP_W;
  localparam int unsigned AMP_RECIP    = 52429;
  localparam int unsigned AMP_SHIFT    = 19;
  localparam int unsigned QUOT_W       = 12;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QDEPTH       = 2;

  typedef enum logic [1:0] {
    KIND_DIGIT     = 2'd0,
    KIND_EVENT_END = 2'd1,
    KIND_READ      = 2'd2,
    KIND_IDLE      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DROPPED  = 2'd1,
    STATUS_BAD_ADDR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_DIGIT     = 3'd1,
    OP_EVENT_END = 3'd2,
    OP_READ_OCC  = 3'd3,
    OP_READ_AMP  = 3'd4
  } op_e;

  // One classified transaction as it waits between the front and back parts.
  typedef struct packed {
    op_e                  op;
    status_e              status;
    logic [1:0]           station;
    logic [1:0]           mod_sel;
    logic                 side;
    logic [HIST_W-1:0]    hist;
    logic [STRIP_W-1:0]   bin;
    logic [AMP_BIN_W-1:0] abin;
  } item_t;

  // First occupancy histogram of each station.
  function automatic logic [HIST_W-1:0] occ_base(input logic [1:0] station);
    logic [HIST_W-1:0] base;
    case (station)
      2'd0:    base = 4'd0;
      2'd1:    base = 4'd4;
      2'd2:    base = 4'd12;
      default: base = 4'd0;
    endcase
    return base;
  endfunction

endpackage

// ===== hw/rtl/strip_occupancy_coincidence_monitor.sv =====
// Top level of the strip occupancy and coincidence monitor.
//
// The block takes a stream of transactions of three kinds: strip digits, end-of-event
// markers and histogram reads, and returns exactly one result transaction for each. A good
// digit adds one to the occupancy histogram of its station, module and side (strips at or
// above STRIP_BINS land in the overflow bin), adds one to its station's histogram of
// |amplitude|/10 (values of AMP_BINS and above in the overflow bin) and marks that side of
// its module as hit. A good digit that names a module the station does not have is dropped
// with status 1. At end of event the event is good when every station has a module with
// both sides hit; good events are counted and all marks are cleared. Reads return one bin,
// or status 2 and zero for an address outside the histograms. All counters saturate at
// 2^COUNT_BITS - 1, and results always carry the good event count so far.
//
// Both sides look like queues: push/full on the input, empty/pop on the output. A front
// part classifies each transaction and works out histogram and bin numbers, a two-entry
// queue decouples it from the back part, and an output register holds the finished result,
// so the input keeps taking transactions while a result waits to be popped.
//
// A digit or a histogram read passes through the idle and execute states of the back end:
// the histogram memories are read in the first, and in the second a digit writes the
// incremented counts back and a read loads its result; end-of-event markers, ignored and
// dropped digits finish in the idle state. Results load only when the output is free.
//
// After reset the histogram memories are swept to zero, one entry a cycle, over
// max(16 * (STRIP_BINS + 1), 3 * (AMP_BINS + 1)) addresses (10256 at the default settings).
// The full output stays high throughout the sweep.
module strip_occupancy_coincidence_monitor #(
  parameter int unsigned STRIP_BINS = 640,
  parameter int unsigned AMP_BINS   = 80,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         kind_i,
  input  logic               good_digit_i,
  input  logic [1:0]         station_i,
  input  logic [1:0]         module_req_i,
  input  logic               side_i,
  input  logic [9:0]         strip_i,
  input  logic signed [15:0] amplitude_i,
  input  logic [4:0]         read_histogram_i,
  input  logic [9:0]         read_bin_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status_o,
  output logic               event_good_o,
  output logic [31:0]        good_event_count_o,
  output logic [31:0]        bin_count_o
);

  logic            q_wr_en;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            clearing;
  socm_pkg::item_t q_wr_item;
  socm_pkg::item_t q_rd_item;

  // Front part: accepts and classifies each transaction.
  socm_front #(
    .STRIP_BINS (STRIP_BINS),
    .AMP_BINS   (AMP_BINS)
  ) u_front (
    .push             (push),
    .full             (full),
    .kind_i           (kind_i),
    .good_digit_i     (good_digit_i),
    .station_i        (station_i),
    .module_req_i     (module_req_i),
    .side_i           (side_i),
    .strip_i          (strip_i),
    .amplitude_i      (amplitude_i),
    .read_histogram_i (read_histogram_i),
    .read_bin_i       (read_bin_i),
    .clearing_i       (clearing),
    .q_full_i         (q_full),
    .wr_en_o          (q_wr_en),
    .wr_item_o        (q_wr_item)
  );

  // The queue lets the front part keep accepting while the back part is busy.
  socm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr_en),
    .wr_item_i (q_wr_item),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .valid_o   (q_valid),
    .rd_item_o (q_rd_item)
  );

  // Back part: updates the histograms and marks, and produces the results.
  socm_back #(
    .STRIP_BINS (STRIP_BINS),
    .AMP_BINS   (AMP_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_item_i           (q_rd_item),
    .q_pop_o            (q_pop),
    .clearing_o         (clearing),
    .empty              (empty),
    .pop                (pop),
    .status_o           (status_o),
    .event_good_o       (event_good_o),
    .good_event_count_o (good_event_count_o),
    .bin_count_o        (bin_count_o)
  );

endmodule

// ===== hw/rtl/socm_queue.sv =====
// Short queue of classified transactions between the front and back parts.
module socm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  socm_pkg::item_t  wr_item_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic             valid_o,
  output socm_pkg::item_t  rd_item_o
);

  localparam int unsigned PTR_W = (socm_pkg::QDEPTH > 1) ? $clog2(socm_pkg::QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(socm_pkg::QDEPTH + 1);

  socm_pkg::item_t  entries_q [socm_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(socm_pkg::QDEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign full_o    = (count_q == CNT_W'(socm_pkg::QDEPTH));
  assign valid_o   = (count_q != '0);
  assign rd_item_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_en_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entries_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// ===== hw/rtl/socm_front.sv =====
// Front part: accepts transactions, checks them and works out histogram and bin numbers.
module socm_front #(
  parameter int unsigned STRIP_BINS = 640,
  parameter int unsigned AMP_BINS   = 80
) (
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      kind_i,
  input  logic                            good_digit_i,
  input  logic [1:0]                      station_i,
  input  logic [1:0]                      module_req_i,
  input  logic                            side_i,
  input  logic [socm_pkg::STRIP_W-1:0]    strip_i,
  input  logic signed [15:0]              amplitude_i,
  input  logic [4:0]                      read_histogram_i,
  input  logic [socm_pkg::STRIP_W-1:0]    read_bin_i,
  input  logic                            clearing_i,
  input  logic                            q_full_i,
  output logic                            wr_en_o,
  output socm_pkg::item_t                 wr_item_o
);

  logic [socm_pkg::MAG_W-1:0]  amp_ext;
  logic [socm_pkg::MAG_W-1:0]  mag;
  logic [socm_pkg::PROD_W-1:0] prod;
  logic [socm_pkg::QUOT_W-1:0] quot;
  logic                        mod_ok;

  assign full    = q_full_i || clearing_i;
  assign wr_en_o = push && !full;

  // Magnitude of the amplitude; the most negative value gives 32768.
  assign amp_ext = {amplitude_i[15], amplitude_i};
  assign mag     = amp_ext[socm_pkg::MAG_W-1] ? (~amp_ext + socm_pkg::MAG_W'(1)) : amp_ext;
  assign prod    = socm_pkg::PROD_W'(mag) * socm_pkg::PROD_W'(socm_pkg::AMP_RECIP);
  assign quot    = socm_pkg::QUOT_W'(prod >> socm_pkg::AMP_SHIFT);

  always_comb begin
    case (station_i)
      2'd0, 2'd2: mod_ok = (module_req_i inside {[2'd0:2'd1]});
      2'd1:       mod_ok = 1'b1;
      default:    mod_ok = 1'b0;
    endcase
  end

  always_comb begin
    wr_item_o         = '0;
    wr_item_o.op      = socm_pkg::OP_NOP;
    wr_item_o.status  = socm_pkg::STATUS_OK;
    case (kind_i)
      socm_pkg::KIND_DIGIT: begin
        if (good_digit_i) begin
          if (mod_ok) begin
            wr_item_o.op      = socm_pkg::OP_DIGIT;
            wr_item_o.station = station_i;
            wr_item_o.mod_sel = module_req_i;
            wr_item_o.side    = side_i;
            wr_item_o.hist    = socm_pkg::occ_base(station_i)
                                + {1'b0, module_req_i, 1'b0} + socm_pkg::HIST_W'(side_i);
            wr_item_o.bin     = (strip_i >= socm_pkg::STRIP_W'(STRIP_BINS))
                                ? socm_pkg::STRIP_W'(STRIP_BINS) : strip_i;
            wr_item_o.abin    = (quot >= socm_pkg::QUOT_W'(AMP_BINS))
                                ? socm_pkg::AMP_BIN_W'(AMP_BINS) : socm_pkg::AMP_BIN_W'(quot);
          end else begin
            wr_item_o.status  = socm_pkg::STATUS_DROPPED;
          end
        end
      end
      socm_pkg::KIND_EVENT_END: begin
        wr_item_o.op = socm_pkg::OP_EVENT_END;
      end
      socm_pkg::KIND_READ: begin
        if (read_histogram_i < 5'(socm_pkg::N_OCC_HIST)
            && read_bin_i <= socm_pkg::STRIP_W'(STRIP_BINS)) begin
          wr_item_o.op   = socm_pkg::OP_READ_OCC;
          wr_item_o.hist = read_histogram_i[socm_pkg::HIST_W-1:0];
          wr_item_o.bin  = read_bin_i;
        end else if (read_histogram_i inside {[5'd16:5'd18]}
                     && read_bin_i <= socm_pkg::STRIP_W'(AMP_BINS)) begin
          // Histograms 16 to 18 map onto stations 0 to 2 by their low bits.
          wr_item_o.op      = socm_pkg::OP_READ_AMP;
          wr_item_o.station = read_histogram_i[1:0];
          wr_item_o.bin     = read_bin_i;
        end else begin
          wr_item_o.status  = socm_pkg::STATUS_BAD_ADDR;
        end
      end
      default: begin
        wr_item_o.op = socm_pkg::OP_NOP;
      end
    endcase
  end

endmodule

// ===== hw/rtl/socm_back.sv =====
// Back part: histogram memories, hit marks, good event counter and result register.
module socm_back #(
  parameter int unsigned STRIP_BINS = 640,
  parameter int unsigned AMP_BINS   = 80,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  socm_pkg::item_t                 q_item_i,
  output logic                            q_pop_o,
  output logic                            clearing_o,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      status_o,
  output logic                            event_good_o,
  output logic [socm_pkg::RESULT_W-1:0]   good_event_count_o,
  output logic [socm_pkg::RESULT_W-1:0]   bin_count_o
);

  localparam int unsigned OCC_DEPTH = socm_pkg::N_OCC_HIST * (STRIP_BINS + 1);
  localparam int unsigned AMP_DEPTH = socm_pkg::N_STATIONS * (AMP_BINS + 1);
  localparam int unsigned OCC_AW    = $clog2(OCC_DEPTH);
  localparam int unsigned AMP_AW    = $clog2(AMP_DEPTH);
  localparam int unsigned CLR_DEPTH = (OCC_DEPTH > AMP_DEPTH) ? OCC_DEPTH : AMP_DEPTH;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [CLR_W-1:0]            clr_cnt_q, clr_cnt_d;
  logic                        clr_last, clr_occ, clr_amp;

  logic [COUNT_BITS-1:0]       occ_mem [OCC_DEPTH];
  logic [COUNT_BITS-1:0]       amp_mem [AMP_DEPTH];
  logic [COUNT_BITS-1:0]       occ_rdata_q, amp_rdata_q;
  logic [OCC_AW-1:0]           occ_raddr, occ_addr_q, occ_waddr;
  logic [AMP_AW-1:0]           amp_raddr, amp_addr_q, amp_waddr, amp_idx;
  logic [COUNT_BITS-1:0]       occ_wdata, amp_wdata;
  logic                        occ_we, amp_we, rd_en;
  socm_pkg::item_t             cur_q;
  logic                        head_mem;

  logic [1:0]                  marks_q [socm_pkg::N_STATIONS][socm_pkg::N_MOD_MAX];
  logic                        mark_set, mark_clear;
  logic [socm_pkg::N_STATIONS-1:0] station_hit;
  logic                        coinc;

  logic [COUNT_BITS-1:0]       count_q, count_d, count_inc;

  logic                        out_valid_q, out_ok, out_load;
  socm_pkg::status_e           res_status_d, res_status_q;
  logic                        res_good_d, res_good_q;
  logic [COUNT_BITS-1:0]       res_bin_d, res_bin_q, res_count_q;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  // Clearing sweep after reset.
  assign clearing_o = (state_q == ST_CLEAR);
  assign clr_last   = (clr_cnt_q == CLR_W'(CLR_DEPTH - 1));
  assign clr_occ    = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(OCC_DEPTH));
  assign clr_amp    = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(AMP_DEPTH));

  // Memory addresses of the transaction at the head of the queue.
  assign head_mem  = (q_item_i.op inside {socm_pkg::OP_DIGIT, socm_pkg::OP_READ_OCC,
                                          socm_pkg::OP_READ_AMP});
  assign amp_idx   = (q_item_i.op == socm_pkg::OP_DIGIT) ? AMP_AW'(q_item_i.abin)
                                                         : AMP_AW'(q_item_i.bin);
  assign occ_raddr = OCC_AW'(q_item_i.hist) * OCC_AW'(STRIP_BINS + 1) + OCC_AW'(q_item_i.bin);
  assign amp_raddr = AMP_AW'(q_item_i.station) * AMP_AW'(AMP_BINS + 1) + amp_idx;
  assign rd_en     = (state_q == ST_IDLE) && q_valid_i && head_mem;

  assign occ_waddr = clearing_o ? clr_cnt_q[OCC_AW-1:0] : occ_addr_q;
  assign amp_waddr = clearing_o ? clr_cnt_q[AMP_AW-1:0] : amp_addr_q;
  assign occ_wdata = clearing_o ? '0 : sat_inc(occ_rdata_q);
  assign amp_wdata = clearing_o ? '0 : sat_inc(amp_rdata_q);

  // Coincidence: some module of every station has both sides hit.
  always_comb begin
    for (int s = 0; s < socm_pkg::N_STATIONS; s++) begin
      station_hit[s] = 1'b0;
      for (int m = 0; m < socm_pkg::N_MOD_MAX; m++) begin
        station_hit[s] = station_hit[s] | (marks_q[s][m] == 2'b11);
      end
    end
  end
  assign coinc     = &station_hit;
  assign count_inc = sat_inc(count_q);
  assign out_ok    = !out_valid_q || pop;

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    q_pop_o      = 1'b0;
    out_load     = 1'b0;
    occ_we       = 1'b0;
    amp_we       = 1'b0;
    mark_set     = 1'b0;
    mark_clear   = 1'b0;
    count_d      = count_q;
    res_status_d = socm_pkg::STATUS_OK;
    res_good_d   = 1'b0;
    res_bin_d    = '0;
    case (state_q)
      ST_CLEAR: begin
        occ_we    = clr_occ;
        amp_we    = clr_amp;
        clr_cnt_d = clr_cnt_q + CLR_W'(1);
        if (clr_last) begin
          clr_cnt_d = '0;
          state_d   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if (head_mem) begin
            q_pop_o = 1'b1;
            state_d = ST_EXEC;
          end else if (out_ok) begin
            q_pop_o      = 1'b1;
            out_load     = 1'b1;
            res_status_d = q_item_i.status;
            if (q_item_i.op == socm_pkg::OP_EVENT_END) begin
              mark_clear = 1'b1;
              res_good_d = coinc;
              count_d    = coinc ? count_inc : count_q;
            end
          end
        end
      end
      ST_EXEC: begin
        if (out_ok) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          case (cur_q.op)
            socm_pkg::OP_DIGIT: begin
              occ_we   = 1'b1;
              amp_we   = 1'b1;
              mark_set = 1'b1;
            end
            socm_pkg::OP_READ_OCC: res_bin_d = occ_rdata_q;
            socm_pkg::OP_READ_AMP: res_bin_d = amp_rdata_q;
            default:               res_bin_d = '0;
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      count_q   <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < socm_pkg::N_STATIONS; s++) begin
        for (int m = 0; m < socm_pkg::N_MOD_MAX; m++) begin
          marks_q[s][m] <= 2'b00;
        end
      end
    end else if (mark_clear) begin
      for (int s = 0; s < socm_pkg::N_STATIONS; s++) begin
        for (int m = 0; m < socm_pkg::N_MOD_MAX; m++) begin
          marks_q[s][m] <= 2'b00;
        end
      end
    end else if (mark_set) begin
      marks_q[cur_q.station][cur_q.mod_sel][cur_q.side] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cur_q      <= q_item_i;
      occ_addr_q <= occ_raddr;
      amp_addr_q <= amp_raddr;
    end
    if (out_load) begin
      res_status_q <= res_status_d;
      res_good_q   <= res_good_d;
      res_bin_q    <= res_bin_d;
      res_count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    if (rd_en) begin
      occ_rdata_q <= occ_mem[occ_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (amp_we) begin
      amp_mem[amp_waddr] <= amp_wdata;
    end
    if (rd_en) begin
      amp_rdata_q <= amp_mem[amp_raddr];
    end
  end

  assign empty              = !out_valid_q;
  assign status_o           = res_status_q;
  assign event_good_o       = res_good_q;
  assign good_event_count_o = socm_pkg::RESULT_W'(res_count_q);
  assign bin_count_o        = socm_pkg::RESULT_W'(res_bin_q);

endmodule

// ===== hw/rtl/socm_checker.sv =====
// Port-level checks of the strip occupancy and coincidence monitor, bound to the top level.
module socm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [1:0]         status_o,
  input logic               event_good_o,
  input logic [31:0]        good_event_count_o,
  input logic [31:0]        bin_count_o
);

  // A waiting result holds until it is popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(event_good_o)
                          && $stable(good_event_count_o) && $stable(bin_count_o)))
    else $error("result changed while waiting to be popped");

  // A good event is never reported alongside an error or bin contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_good_o) |-> (status_o == socm_pkg::STATUS_OK && bin_count_o == 32'd0))
    else $error("good event result carries status or bin contents");

  // An error result reports no bin contents and no good event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != socm_pkg::STATUS_OK) |-> (bin_count_o == 32'd0 && !event_good_o))
    else $error("error result carries bin contents or a good event");

  // Once a good event has been reported the count cannot be zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && event_good_o) |-> (good_event_count_o != 32'd0))
    else $error("good event reported with a zero good event count");

endmodule

bind strip_occupancy_coincidence_monitor socm_checker u_socm_checker (.*);
